// ===== rtl/swbm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the sample window buffer manager.
package swbm_pkg;

	// Field widths
	localparam int unsigned FRAME_W = 32;
	localparam int unsigned COUNT_W = 24;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_TOTAL_SAMPLES = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BUFFER_CAPACITY = 1'd1;

	localparam logic [FRAME_W-1:0] TOTAL_RESET = 32'd1;
	localparam logic [COUNT_W-1:0] CAPACITY_RESET = 24'd2725380;

	// Default depth of the plan queue between front and back
	localparam int unsigned QUEUE_DEPTH_DEF = 2;

	// Reciprocals for exact floor division of values below 2^25
	localparam int unsigned SHIFT50 = 30;
	localparam int unsigned SHIFT100 = 31;
	localparam logic [24:0] RECIP50 = 25'((64'd1 << SHIFT50) / 64'd50 + 64'd1);
	localparam logic [24:0] RECIP100 = 25'((64'd1 << SHIFT100) / 64'd100 + 64'd1);

	typedef enum logic [2:0] {
		KIND_HIT      = 3'd0,
		KIND_FETCH    = 3'd1,
		KIND_MOVE     = 3'd2,
		KIND_TOO_LONG = 3'd3,
		KIND_BAD      = 3'd4
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [FRAME_W-1:0] src;
		logic [COUNT_W-1:0] cnt;
		logic [COUNT_W-1:0] dst;
	} cmd_t;

	// One request's worth of commands, issued in order cmds[0] .. cmds[n_cmd-1]
	typedef struct packed {
		logic [1:0]      n_cmd;
		cmd_t [2:0]      cmds;
	} plan_t;

	// Front to queue push handshake
	typedef struct packed {
		logic  valid;
		plan_t plan;
	} push_t;

endpackage

// ===== rtl/swbm_front.sv =====
`timescale 1ns / 1ps
// Front end: request pipeline, window arithmetic, held-span tracking, plan build.
module swbm_front import swbm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [FRAME_W-1:0] request_first,
	input  logic [FRAME_W-1:0] request_last,
	input  logic [FRAME_W-1:0] total_samples,
	input  logic [COUNT_W-1:0] buffer_capacity,
	output push_t              push,
	input  logic               q_full
);

	function automatic logic [FRAME_W-1:0] fld32(input logic signed [33:0] v);
		fld32 = v[33] ? '0 : v[FRAME_W-1:0];
	endfunction

	function automatic logic [COUNT_W-1:0] fld24(input logic signed [33:0] v);
		fld24 = v[33] ? '0 : v[COUNT_W-1:0];
	endfunction

	logic [FRAME_W-1:0] tot;
	logic adv;

	// stage valids
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	// request fields through the pipe
	logic [FRAME_W-1:0] f_s1, f_s2, f_s3, f_s4, f_s5, f_s6;
	logic [FRAME_W-1:0] l_s1, l_s2, l_s3, l_s4, l_s5, l_s6;
	logic bad_s2, bad_s3, bad_s4, bad_s5, bad_s6;
	logic too_s2, too_s3, too_s4, too_s5, too_s6;

	logic [COUNT_W-1:0] n_s2, n_s3;
	logic [18:0] q50_s3, c100_s3;
	logic [24:0] w_s4, w_s5;
	logic [FRAME_W-1:0] lo_s4, hi_s5, lo_s6, hi_s6;

	logic [FRAME_W-1:0] held_first_q, held_last_q;

	// stage 2 logic
	logic [FRAME_W-1:0] n1;
	logic [38:0] n39, c39, lhs39, rhs39;
	logic bad1;

	// stage 3 logic
	logic [48:0] p50;
	logic [24:0] np99;
	logic [49:0] p100;

	// stage 4..6 logic
	logic signed [33:0] lo_a, lo_b;
	logic [32:0] hi_a;

	// commit logic
	logic signed [33:0] sf, sl, shf, shl, slo, shi, scap;
	logic hit, ext, disjoint;
	plan_t plan_d;

	assign tot = (total_samples == '0) ? TOTAL_RESET : total_samples;

	// whole pipe moves unless the finished plan has nowhere to go
	assign adv = !(v_s6 && q_full);
	assign req_stall = !adv;

	// stage 2: validity, length, too-long test
	always_comb begin
		n1 = l_s1 - f_s1 + 32'd1;
		bad1 = (f_s1 == '0) || (f_s1 > l_s1) || (l_s1 > tot);
		n39 = 39'(n1);
		c39 = 39'(buffer_capacity);
		lhs39 = (n39 << 5) + (n39 << 4) + (n39 << 1) + n39 + 39'd50;
		rhs39 = (c39 << 5) + (c39 << 4) + (c39 << 1);
	end

	// stage 3: n/50 and ceil(n/100) by reciprocal; n < 2^24 once too-long is ruled out
	always_comb begin
		p50 = 49'(n_s2) * 49'(RECIP50);
		np99 = 25'(n_s2) + 25'd99;
		p100 = 50'(np99) * 50'(RECIP100);
	end

	// stage 4..6: widen and clamp the window
	always_comb begin
		lo_a = signed'({2'b00, f_s3}) - signed'(34'(c100_s3));
		hi_a = {1'b0, lo_s4} + 33'(w_s4);
		lo_b = signed'({2'b00, hi_s5}) - signed'(34'(w_s5));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= req_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			f_s1 <= request_first;
			l_s1 <= request_last;

			f_s2 <= f_s1;
			l_s2 <= l_s1;
			bad_s2 <= bad1;
			too_s2 <= lhs39 > rhs39;
			n_s2 <= n1[COUNT_W-1:0];

			f_s3 <= f_s2;
			l_s3 <= l_s2;
			bad_s3 <= bad_s2;
			too_s3 <= too_s2;
			n_s3 <= n_s2;
			q50_s3 <= p50[48:SHIFT50];
			c100_s3 <= p100[49:SHIFT100];

			f_s4 <= f_s3;
			l_s4 <= l_s3;
			bad_s4 <= bad_s3;
			too_s4 <= too_s3;
			w_s4 <= 25'(n_s3) + 25'(q50_s3);
			lo_s4 <= (lo_a < 34'sd1) ? 32'd1 : lo_a[FRAME_W-1:0];

			f_s5 <= f_s4;
			l_s5 <= l_s4;
			bad_s5 <= bad_s4;
			too_s5 <= too_s4;
			w_s5 <= w_s4;
			hi_s5 <= (hi_a > {1'b0, tot}) ? tot : hi_a[FRAME_W-1:0];

			f_s6 <= f_s5;
			l_s6 <= l_s5;
			bad_s6 <= bad_s5;
			too_s6 <= too_s5;
			hi_s6 <= hi_s5;
			lo_s6 <= (lo_b < 34'sd1) ? 32'd1 : lo_b[FRAME_W-1:0];
		end
	end

	// commit: classify against the held span and build the command list
	always_comb begin
		sf = signed'({2'b00, f_s6});
		sl = signed'({2'b00, l_s6});
		shf = signed'({2'b00, held_first_q});
		shl = signed'({2'b00, held_last_q});
		slo = signed'({2'b00, lo_s6});
		shi = signed'({2'b00, hi_s6});
		scap = signed'(34'(buffer_capacity));
		hit = (sf >= shf) && (sl <= shl);
		ext = (sf >= shf) && ((sl - shf + 34'sd1) <= scap);
		disjoint = (shi < shf) || (slo > shl);

		plan_d = '0;
		plan_d.n_cmd = 2'd1;
		if (bad_s6) begin
			plan_d.cmds[0].kind = KIND_BAD;
		end else if (too_s6) begin
			plan_d.cmds[0].kind = KIND_TOO_LONG;
		end else if (hit) begin
			plan_d.cmds[0].kind = KIND_HIT;
		end else if (ext) begin
			plan_d.cmds[0] = '{KIND_FETCH, fld32(shl + 34'sd1), fld24(sl - shl),
				fld24(shl - shf + 34'sd1)};
		end else if (disjoint) begin
			plan_d.cmds[0] = '{KIND_FETCH, fld32(slo), fld24(shi - slo + 34'sd1), '0};
		end else if (slo < shf) begin
			if (shi <= shl) begin
				plan_d.n_cmd = 2'd2;
				plan_d.cmds[0] = '{KIND_MOVE, '0, fld24(shi - shf + 34'sd1), fld24(shf - slo)};
				plan_d.cmds[1] = '{KIND_FETCH, fld32(slo), fld24(shf - slo), '0};
			end else begin
				plan_d.n_cmd = 2'd3;
				plan_d.cmds[0] = '{KIND_MOVE, '0, fld24(shl - shf + 34'sd1), fld24(shf - slo)};
				plan_d.cmds[1] = '{KIND_FETCH, fld32(slo), fld24(shf - slo), '0};
				plan_d.cmds[2] = '{KIND_FETCH, fld32(shl + 34'sd1), fld24(shi - shl),
					fld24(shl - slo + 34'sd1)};
			end
		end else begin
			plan_d.n_cmd = 2'd2;
			plan_d.cmds[0] = '{KIND_MOVE, fld32(slo - shf), fld24(shl - slo + 34'sd1), '0};
			plan_d.cmds[1] = '{KIND_FETCH, fld32(shl + 34'sd1), fld24(shi - shl),
				fld24(shl - slo + 34'sd1)};
		end
	end

	assign push.valid = v_s6 && !q_full;
	assign push.plan = plan_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_first_q <= 32'd1;
			held_last_q <= '0;
		end else if (push.valid && !bad_s6 && !too_s6 && !hit) begin
			if (ext) begin
				held_last_q <= l_s6;
			end else begin
				held_first_q <= lo_s6;
				held_last_q <= hi_s6;
			end
		end
	end

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> v_s1)
		else $error("accepted item did not enter stage 1");

	a_held_first_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |=> (held_first_q != '0))
		else $error("held span start became zero");

endmodule

// ===== rtl/swbm_queue.sv =====
`timescale 1ns / 1ps
// Short plan queue between the front and back ends.
module swbm_queue import swbm_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  push_t push,
	output logic  full,
	input  logic  pop,
	output logic  empty,
	output plan_t head
);

	localparam int unsigned PW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	plan_t mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] count_q;
	logic do_pop;

	assign full = (count_q == FULL_CNT);
	assign empty = (count_q == '0);
	assign head = mem_q[rd_q];
	assign do_pop = pop && !empty;

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_q] <= push.plan;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (push.valid) begin
				wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + PW'(1);
			end
			if (push.valid && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (!push.valid && do_pop) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("queue count beyond depth");

endmodule

// ===== rtl/swbm_back.sv =====
`timescale 1ns / 1ps
// Back end: steps through a plan and issues one command per cycle while cmd_stall is low.
module swbm_back import swbm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  plan_t              head,
	output logic               pop,
	output logic               cmd_valid,
	input  logic               cmd_stall,
	output logic [2:0]         kind,
	output logic [FRAME_W-1:0] source_start,
	output logic [COUNT_W-1:0] frame_count,
	output logic [COUNT_W-1:0] dest_offset,
	output logic               last_of_run
);

	logic [1:0] idx_q;
	logic out_valid_q;
	cmd_t cmd_q;
	logic last_q;
	logic load, at_last;

	assign load = !q_empty && (!out_valid_q || !cmd_stall);
	assign at_last = (idx_q == head.n_cmd - 2'd1);
	assign pop = load && at_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q <= at_last ? 2'd0 : idx_q + 2'd1;
			end else if (!cmd_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cmd_q <= head.cmds[idx_q];
			last_q <= at_last;
		end
	end

	assign cmd_valid = out_valid_q;
	assign kind = cmd_q.kind;
	assign source_start = cmd_q.src;
	assign frame_count = cmd_q.cnt;
	assign dest_offset = cmd_q.dst;
	assign last_of_run = last_q;

	a_plan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		!q_empty |-> (head.n_cmd != 2'd0))
		else $error("plan with no commands at queue head");

	a_idx_in_plan: assert property (@(posedge clk) disable iff (!arst_n)
		!q_empty |-> (idx_q < head.n_cmd))
		else $error("command index past end of plan");

endmodule

// ===== rtl/sample_window_buffer_manager.sv =====
`timescale 1ns / 1ps
// Top level of the sample window buffer manager: config registers, front, queue, back.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+---------------------------------------------------
//  request  | req_valid / req_stall | request_first, request_last
//  command  | cmd_valid / cmd_stall | kind, source_start, frame_count, dest_offset,
//           |                       | last_of_run
//  config   | cfg_wr_en             | cfg_index, cfg_data (0 total_samples, 1 capacity)
//
// The front is a six-stage pipe and takes a request every cycle while the plan
// queue has room; the last stage compares against the held span and commits.
// The back issues one command per cycle while cmd_stall is low, so a request costs 1 to 3
// commands; its plan passes the front stages and the queue into the output register.
// Reset clears the pipe, the queue and the held span (empty buffer) at once.
// req_stall rises only when a finished plan waits on a full queue; cmd_stall
// holds the output register and backs up into the queue.
module sample_window_buffer_manager import swbm_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [FRAME_W-1:0]   cfg_data,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  logic [FRAME_W-1:0]   request_first,
	input  logic [FRAME_W-1:0]   request_last,
	output logic                 cmd_valid,
	input  logic                 cmd_stall,
	output logic [2:0]           kind,
	output logic [FRAME_W-1:0]   source_start,
	output logic [COUNT_W-1:0]   frame_count,
	output logic [COUNT_W-1:0]   dest_offset,
	output logic                 last_of_run
);

	logic [FRAME_W-1:0] total_q;
	logic [COUNT_W-1:0] capacity_q;

	push_t push;
	logic q_full, q_empty, pop;
	plan_t head;

	// Config writes must come only while idle (the block itself does not enforce it); the pipe reads these directly.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= TOTAL_RESET;
			capacity_q <= CAPACITY_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_TOTAL_SAMPLES: begin
					total_q <= cfg_data;
				end
				REG_BUFFER_CAPACITY: begin
					capacity_q <= cfg_data[COUNT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Front: validate, size, widen, classify against the held span
	swbm_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_valid       (req_valid),
		.req_stall       (req_stall),
		.request_first   (request_first),
		.request_last    (request_last),
		.total_samples   (total_q),
		.buffer_capacity (capacity_q),
		.push            (push),
		.q_full          (q_full)
	);

	// Plans wait here so front and back stall independently
	swbm_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (q_full),
		.pop    (pop),
		.empty  (q_empty),
		.head   (head)
	);

	// Back: one command item per cycle into the output register while cmd_stall is low
	swbm_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.head         (head),
		.pop          (pop),
		.cmd_valid    (cmd_valid),
		.cmd_stall    (cmd_stall),
		.kind         (kind),
		.source_start (source_start),
		.frame_count  (frame_count),
		.dest_offset  (dest_offset),
		.last_of_run  (last_of_run)
	);

endmodule

// ===== sim/swbm_command_checker.sv =====
`timescale 1ns / 1ps
// Command scoreboard for the sample window buffer manager: predicts and compares commands.
module swbm_command_checker import swbm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [FRAME_W-1:0]   cfg_data,
	input  logic                 req_valid,
	input  logic                 req_stall,
	input  logic [FRAME_W-1:0]   request_first,
	input  logic [FRAME_W-1:0]   request_last,
	input  logic                 cmd_valid,
	input  logic                 cmd_stall,
	input  logic [2:0]           kind,
	input  logic [FRAME_W-1:0]   source_start,
	input  logic [COUNT_W-1:0]   frame_count,
	input  logic [COUNT_W-1:0]   dest_offset,
	input  logic                 last_of_run,
	output int                   error_count,
	output int                   outstanding
);

	typedef struct {
		kind_t              kind;
		logic [FRAME_W-1:0] src;
		logic [COUNT_W-1:0] cnt;
		logic [COUNT_W-1:0] dst;
		logic               fin;
	} command_t;

	command_t           expected_cmds[$];
	command_t           want;
	logic [FRAME_W-1:0] total_reg;
	logic [COUNT_W-1:0] capacity_reg;
	longint             span_first;
	longint             span_last;

	// negative counts and offsets go out as zero, then masked to field width
	function automatic void queue_cmd(kind_t k, longint src, longint cnt, longint dst,
			logic fin);
		command_t c;
		c.kind = k;
		c.src = (src < 0) ? '0 : src[FRAME_W-1:0];
		c.cnt = (cnt < 0) ? '0 : cnt[COUNT_W-1:0];
		c.dst = (dst < 0) ? '0 : dst[COUNT_W-1:0];
		c.fin = fin;
		expected_cmds.push_back(c);
	endfunction

	function automatic int field_diff(string name, logic [FRAME_W-1:0] exp_val,
			logic [FRAME_W-1:0] got_val);
		if (got_val !== exp_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, got_val);
			return 1;
		end
		return 0;
	endfunction

	// commands that make frames first..last resident, updating the held span
	task automatic plan_residency(logic [FRAME_W-1:0] first_in, logic [FRAME_W-1:0] last_in);
		longint f, l, tot, cap, hf, hl, n, w, lo, hi;
		f = longint'(first_in);
		l = longint'(last_in);
		tot = longint'(total_reg);
		if (tot == 0)
			tot = 1;
		cap = longint'(capacity_reg);
		hf = span_first;
		hl = span_last;
		if (f == 0 || f > l || l > tot) begin
			queue_cmd(KIND_BAD, 0, 0, 0, 1'b1);
		end else begin
			n = l - f + 1;
			if (51 * n + 50 > 50 * cap) begin
				queue_cmd(KIND_TOO_LONG, 0, 0, 0, 1'b1);
			end else if (f >= hf && l <= hl) begin
				queue_cmd(KIND_HIT, 0, 0, 0, 1'b1);
			end else if (f >= hf && l - hf + 1 <= cap) begin
				// grow the span to the right in place
				queue_cmd(KIND_FETCH, hl + 1, l - hl, hl - hf + 1, 1'b1);
				span_last = l;
			end else begin
				// widened window: 1% margin ahead, 2% extra length
				w = n + n / 50;
				lo = f - (n + 99) / 100;
				if (lo < 1)
					lo = 1;
				hi = lo + w;
				if (hi > tot)
					hi = tot;
				lo = hi - w;
				if (lo < 1)
					lo = 1;
				span_first = lo;
				span_last = hi;
				if (hi < hf || lo > hl) begin
					queue_cmd(KIND_FETCH, lo, hi - lo + 1, 0, 1'b1);
				end else if (lo < hf && hi <= hl) begin
					queue_cmd(KIND_MOVE, 0, hi - hf + 1, hf - lo, 1'b0);
					queue_cmd(KIND_FETCH, lo, hf - lo, 0, 1'b1);
				end else if (lo < hf) begin
					queue_cmd(KIND_MOVE, 0, hl - hf + 1, hf - lo, 1'b0);
					queue_cmd(KIND_FETCH, lo, hf - lo, 0, 1'b0);
					queue_cmd(KIND_FETCH, hl + 1, hi - hl, hl - lo + 1, 1'b1);
				end else begin
					queue_cmd(KIND_MOVE, lo - hf, hl - lo + 1, 0, 1'b0);
					queue_cmd(KIND_FETCH, hl + 1, hi - hl, hl - lo + 1, 1'b1);
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_reg = TOTAL_RESET;
			capacity_reg = CAPACITY_RESET;
			span_first = 1;
			span_last = 0;
			expected_cmds.delete();
			error_count = 0;
		end else begin
			if (cmd_valid && !cmd_stall) begin
				if (expected_cmds.size() == 0) begin
					$error("unexpected command: kind %0d source_start %0d frame_count %0d",
						kind, source_start, frame_count);
					error_count++;
				end else begin
					want = expected_cmds.pop_front();
					error_count += field_diff("kind", 32'(want.kind), 32'(kind));
					error_count += field_diff("source_start", want.src, source_start);
					error_count += field_diff("frame_count", 32'(want.cnt), 32'(frame_count));
					error_count += field_diff("dest_offset", 32'(want.dst), 32'(dest_offset));
					error_count += field_diff("last_of_run", 32'(want.fin), 32'(last_of_run));
				end
			end
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_TOTAL_SAMPLES: total_reg = cfg_data;
					REG_BUFFER_CAPACITY: capacity_reg = cfg_data[COUNT_W-1:0];
					default: ;
				endcase
			end
			if (req_valid && !req_stall)
				plan_residency(request_first, request_last);
		end
		outstanding = expected_cmds.size();
	end

endmodule

// ===== sim/sample_window_buffer_manager_test.sv =====
`timescale 1ns / 1ps
// Testbench top for the sample window buffer manager: stimulus, flow control and verdict.
module sample_window_buffer_manager_test;
	import swbm_pkg::*;

	// Longest legal quiet stretch is the receiver hold-off plus pipe latency,
	// so the watchdog sits well above it.
	localparam int STUCK_LIMIT = 4000;
	localparam int HOLD_CYCLES = 200;
	localparam int PHASE_ITEMS = 50;
	localparam int N_PHASES = 8;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [FRAME_W-1:0]   cfg_data;
	logic                 req_valid;
	logic                 req_stall;
	logic [FRAME_W-1:0]   request_first;
	logic [FRAME_W-1:0]   request_last;
	logic                 cmd_valid;
	logic                 cmd_stall;
	logic [2:0]           kind;
	logic [FRAME_W-1:0]   source_start;
	logic [COUNT_W-1:0]   frame_count;
	logic [COUNT_W-1:0]   dest_offset;
	logic                 last_of_run;
	int                   error_count;
	int                   outstanding;

	// steady: no idling on either side; hold_req: ask the receiver for a long hold-off
	bit                   steady;
	bit                   hold_req;
	int                   stuck_cycles;

	// the sender's copy of the registers, used only to shape requests
	logic [FRAME_W-1:0]   cur_total;
	logic [COUNT_W-1:0]   cur_cap;
	longint               cursor;

	always #6 clk = ~clk;

	sample_window_buffer_manager DUT (.*);

	swbm_command_checker scoreboard (.*);

	// Watchdog: any cycle that moves an item on either channel resets the count.
	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (cmd_valid && !cmd_stall)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles == STUCK_LIMIT) begin
			$display("sample_window_buffer_manager verification failed");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	// Command receiver: random stalls about 15% of cycles, none in steady stretches,
	// and one long hold-off on request so the plan queue backs up into the request port.
	initial begin
		cmd_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				cmd_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			cmd_stall <= !steady && ($urandom_range(99) < 15);
		end
	end

	// Entered and left just after a falling edge. Valid stays high from one item
	// to the next unless an idle gap is drawn.
	task automatic send_request(logic [FRAME_W-1:0] first, logic [FRAME_W-1:0] last);
		int gap;
		gap = 0;
		if (!steady)
			while ($urandom_range(99) < 15)
				gap++;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		request_first <= first;
		request_last <= last;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Sender stops and waits for every predicted command, then idles a while before going on.
	task automatic drain();
		req_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	// Writes both registers back to back; capacity gets junk in the unused top byte.
	task automatic load_config(logic [FRAME_W-1:0] total, logic [COUNT_W-1:0] cap);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_TOTAL_SAMPLES;
		cfg_data <= total;
		@(negedge clk);
		cfg_index <= REG_BUFFER_CAPACITY;
		cfg_data <= {8'($urandom_range(255)), cap};
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		cur_total = total;
		cur_cap = cap;
	endtask

	// Viewer-like traffic: windows scroll around a cursor, with sizes spread up to
	// the too-long limit, plus some too-long and malformed requests.
	task automatic next_request(output logic [FRAME_W-1:0] first,
			output logic [FRAME_W-1:0] last);
		longint tot, lim, lim4, limx, n, lo;
		int pick, r;
		tot = longint'(cur_total);
		if (tot == 0)
			tot = 1;
		lim = (50 * longint'(cur_cap) - 50) / 51;
		lim4 = (lim / 4 > 1) ? lim / 4 : 1;
		limx = (lim > 1) ? lim : 1;
		pick = $urandom_range(99);
		if (pick < 10) begin
			case ($urandom_range(3))
				0: begin
					first = '0;
					last = $urandom;
				end
				1: begin
					// reversed range
					last = $urandom_range(32'hFFFF_FFFE, 0);
					first = $urandom_range(32'hFFFF_FFFF, last + 1);
				end
				2: begin
					if (tot < 64'h0_FFFF_FFFF) begin
						last = $urandom_range(32'hFFFF_FFFF, 32'(tot + 1));
						first = $urandom_range(last, 1);
					end else begin
						first = $urandom;
						last = $urandom;
					end
				end
				default: begin
					first = $urandom;
					last = $urandom;
				end
			endcase
		end else begin
			if (pick < 18) begin
				n = lim + 1 + longint'($urandom_range(3));
			end else begin
				r = $urandom_range(9);
				if (r < 5)
					n = longint'($urandom_range(32'(lim4), 1));
				else if (r < 8)
					n = longint'($urandom_range(32'(limx), 32'(lim4)));
				else
					n = limx - longint'($urandom_range(2));
				if (n < 1)
					n = 1;
			end
			if (n > tot)
				n = tot;
			if ($urandom_range(9) == 0)
				cursor = longint'($urandom_range(32'(tot), 1));
			lo = cursor - n + longint'($urandom_range(32'(2 * n)));
			if (lo > tot - n + 1)
				lo = tot - n + 1;
			if (lo < 1)
				lo = 1;
			cursor = lo;
			first = lo[FRAME_W-1:0];
			last = 32'(lo + n - 1);
		end
	endtask

	// Register settings for the random phases, extremes included.
	task automatic phase_setting(int phase, output logic [FRAME_W-1:0] total,
			output logic [COUNT_W-1:0] cap);
		case (phase)
			0: begin total = 32'd100000; cap = 24'd1000; end
			1: begin total = 32'hFFFF_FFFF; cap = 24'hFF_FFFF; end
			2: begin total = 32'd5000; cap = 24'd300; end
			3: begin total = $urandom; cap = 24'($urandom_range(4000, 1)); end
			4: begin total = 32'd2000000; cap = CAPACITY_RESET; end
			5: begin total = 32'd300; cap = 24'd40; end
			6: begin total = 32'd64; cap = 24'hFF_FFFF; end
			default: begin total = 32'hFFFF_FFFF; cap = 24'd50; end
		endcase
	endtask

	initial begin
		logic [FRAME_W-1:0] first, last, total;
		logic [COUNT_W-1:0] cap;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_TOTAL_SAMPLES;
		cfg_data = '0;
		req_valid = 1'b0;
		request_first = '0;
		request_last = '0;
		steady = 1'b0;
		hold_req = 1'b0;
		cur_total = TOTAL_RESET;
		cur_cap = CAPACITY_RESET;
		cursor = 1;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// --- directed: reset registers, empty buffer ---
		send_request(32'd1, 32'd1);             // first fill into an empty buffer
		send_request(32'd1, 32'd1);             // hit
		send_request(32'd0, 32'd1);             // zero first frame
		send_request(32'd1, 32'd2);             // past the end of the recording
		drain();

		// zero total behaves as one frame; capacity 1 makes every well-formed request too long
		load_config(32'd0, 24'd1);
		send_request(32'd1, 32'd1);
		send_request(32'hFFFF_FFFF, 32'd1);     // first after last
		drain();

		// mid-size recording, small buffer: walk through every layout case
		load_config(32'd100000, 24'd1000);
		send_request(32'd1, 32'd1);             // span kept over the register change: hit
		send_request(32'd1, 32'd500);           // extend to the right
		send_request(32'd2000, 32'd3000);       // too long
		send_request(32'd5000, 32'd5099);       // widened, no overlap
		send_request(32'd4950, 32'd5049);       // overlap on the left only
		send_request(32'd4900, 32'd5200);       // overlap on both sides
		send_request(32'd5150, 32'd5950);       // overlap on the right only
		send_request(32'd99990, 32'd100000);    // window ends at the last frame
		send_request(32'd1, 32'd10);            // window clamped at frame 1
		send_request(32'd1, 32'd100001);        // past the end
		send_request(32'd20001, 32'd20979);     // longest range that fits
		send_request(32'd30001, 32'd30980);     // one frame too many
		drain();

		// full-width recording and buffer
		load_config(32'hFFFF_FFFF, 24'hFF_FFFF);
		send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(32'd1, 32'hFFFF_FFFF);
		send_request(32'hFFFF_FF00, 32'hFFFF_FFFF);
		drain();

		// --- random phases, each with its own register setting ---
		for (int phase = 0; phase < N_PHASES; phase++) begin
			drain();
			phase_setting(phase, total, cap);
			load_config(total, cap);
			cursor = 1;
			// one phase runs with no idling at all
			steady = (phase == 4);
			for (int item = 0; item < PHASE_ITEMS; item++) begin
				// long receiver hold-off while requests keep coming
				if (phase == 2 && item == 10)
					hold_req = 1'b1;
				next_request(first, last);
				send_request(first, last);
			end
			steady = 1'b0;
		end

		req_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (error_count == 0)
			$display("sample_window_buffer_manager verification clean");
		else
			$display("sample_window_buffer_manager verification failed");
		$finish;
	end

endmodule
